// ===== rtl/rbi_pkg.sv =====
// Package for the rigid body integrator: fixed-point constants, command codes,
// register indexes, shared types and saturating helpers. No dependencies.
package rbi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NLANES = 3;
	localparam int QV_SHIFT = 30 - FRAC_BITS;
	localparam logic [30:0] ONE_FX = 31'(64'(1) << FRAC_BITS);
	localparam logic [30:0] MASS_MIN_RAW = 31'(((64'(1) << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [30:0] MASS_MIN = (MASS_MIN_RAW == 31'd0) ? 31'd1 : MASS_MIN_RAW;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic [16:0] LIN_DRAG_RST = 17'(((64'(1) << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [16:0] ANG_DRAG_RST = 17'(((64'(1) << FRAC_BITS) + 64'd10) / 64'd20);
	localparam int DIV_BITS = 32 + FRAC_BITS;

	localparam logic [3:0] CMD_TICK    = 4'd0;
	localparam logic [3:0] CMD_FORCE   = 4'd1;
	localparam logic [3:0] CMD_TORQUE  = 4'd2;
	localparam logic [3:0] CMD_IMPULSE = 4'd3;
	localparam logic [3:0] CMD_AIMP    = 4'd4;
	localparam logic [3:0] CMD_SETVEL  = 4'd5;
	localparam logic [3:0] CMD_SETAVEL = 4'd6;
	localparam logic [3:0] CMD_SETPOS  = 4'd7;
	localparam logic [3:0] CMD_SETROT  = 4'd8;

	localparam logic [2:0] REG_MASS   = 3'd0;
	localparam logic [2:0] REG_LDRAG  = 3'd1;
	localparam logic [2:0] REG_ADRAG  = 3'd2;
	localparam logic [2:0] REG_MODE   = 3'd3;
	localparam logic [2:0] REG_GRAV_X = 3'd4;
	localparam logic [2:0] REG_GRAV_Y = 3'd5;
	localparam logic [2:0] REG_GRAV_Z = 3'd6;

	typedef logic signed [31:0] fx_t;
	typedef fx_t vec3_t [NLANES];

	// Control word from the sequencer to every lane.
	typedef struct packed {
		logic       start;
		logic       use_grav;
		logic       frozen;
		logic [2:0] op;
	} lane_ctl_t;

	localparam logic [2:0] LOP_TICK    = 3'd0;
	localparam logic [2:0] LOP_IMPULSE = 3'd1;

	function automatic fx_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fff_ffff;
		if (v < -66'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

// ===== rtl/rbi_lane.sv =====
// One axis lane: divide by mass (restoring, one bit per cycle), then the
// velocity, position and spin updates with one shared multiplier. Uses rbi_pkg.
module rbi_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  rbi_pkg::lane_ctl_t  ctl,
	input  rbi_pkg::fx_t        num,
	input  logic [30:0]         mass_eff,
	input  logic [16:0]         dt,
	input  rbi_pkg::fx_t        grav,
	input  logic [16:0]         lin_keep,
	input  logic [16:0]         ang_keep,
	input  rbi_pkg::fx_t        torque,
	input  rbi_pkg::fx_t        vel_in,
	input  rbi_pkg::fx_t        spin_in,
	input  rbi_pkg::fx_t        pos_in,
	output rbi_pkg::fx_t        vel_out,
	output rbi_pkg::fx_t        spin_out,
	output rbi_pkg::fx_t        pos_out,
	output rbi_pkg::fx_t        half_out,
	output logic                done
);
	import rbi_pkg::*;

	typedef enum logic [6:0] {
		L_IDLE = 7'b0000001, L_DIV  = 7'b0000010, L_VEL  = 7'b0000100,
		L_DRAG = 7'b0001000, L_POS  = 7'b0010000, L_SPIN = 7'b0100000,
		L_HALF = 7'b1000000
	} lst_t;

	lst_t              st_q;
	logic [2:0]        op_q;
	logic              grav_q, frz_q;
	logic              neg_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [31:0]       rem_q;
	logic [5:0]        cnt_q;
	logic [1:0]        sub_q;
	fx_t               vel_q, spin_q, pos_q, half_q;

	logic [32:0]       trial;
	logic [31:0]       rem_sh;
	logic signed [DIV_BITS+1:0] qs;
	fx_t               acc;
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [63:0] prod;
	logic signed [65:0] prod_fl;
	logic signed [65:0] prod_h;
	logic [31:0]       nabs;

	assign nabs = num[31] ? 32'(-num) : 32'(num);
	assign rem_sh = {rem_q[30:0], dvd_q[DIV_BITS-1]};
	assign trial = {1'b0, rem_sh} - {2'b0, mass_eff};
	assign qs = neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});

	always_comb begin
		acc = sat32(66'(qs));
		if (grav_q) acc = sat32(66'(acc) + 66'(grav));
	end

	// Shared multiplier operand select; the product is floored by FRAC_BITS.
	always_comb begin
		ma = vel_q;
		mb = $signed({15'b0, dt});
		case (st_q)
			L_VEL:  begin ma = acc; mb = $signed({15'b0, dt}); end
			L_DRAG: begin
				if (sub_q == 2'd0) begin ma = vel_q; mb = $signed({15'b0, lin_keep}); end
				else begin ma = spin_q; mb = $signed({15'b0, ang_keep}); end
			end
			L_POS:  begin ma = vel_q; mb = $signed({15'b0, dt}); end
			L_SPIN: begin ma = torque; mb = $signed({15'b0, dt}); end
			L_HALF: begin ma = spin_q; mb = $signed({15'b0, dt}); end
			default: begin ma = vel_q; mb = $signed({15'b0, dt}); end
		endcase
	end
	assign prod = ma * mb;
	assign prod_fl = 66'(prod >>> FRAC_BITS);
	assign prod_h = 66'(prod >>> (FRAC_BITS + 1)) <<< QV_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			cnt_q <= '0;
			sub_q <= '0;
		end else begin
			case (st_q)
				L_IDLE: if (ctl.start) begin
					st_q <= L_DIV;
					cnt_q <= 6'(DIV_BITS);
				end
				L_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) st_q <= (op_q == LOP_IMPULSE) ? L_IDLE : L_VEL;
				end
				L_VEL:  begin st_q <= L_DRAG; sub_q <= 2'd0; end
				L_DRAG: st_q <= (sub_q == 2'd1) ? L_HALF : L_POS;
				L_POS:  st_q <= frz_q ? L_IDLE : L_SPIN;
				L_SPIN: begin st_q <= L_DRAG; sub_q <= 2'd1; end
				L_HALF: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: if (ctl.start) begin
				op_q <= ctl.op;
				grav_q <= ctl.use_grav;
				frz_q <= ctl.frozen;
				neg_q <= num[31];
				dvd_q <= {nabs, FRAC_BITS'(0)};
				quo_q <= '0;
				rem_q <= '0;
				vel_q <= vel_in;
				spin_q <= spin_in;
				pos_q <= pos_in;
				half_q <= '0;
			end
			L_DIV: begin
				dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
				end
				if (cnt_q == 6'd1 && op_q == LOP_IMPULSE) vel_q <= vel_q;
			end
			L_VEL:  vel_q <= sat32(66'(vel_q) + sat32(prod_fl));
			L_DRAG: begin
				if (sub_q == 2'd0) vel_q <= sat32(prod_fl);
				else spin_q <= sat32(prod_fl);
			end
			L_POS:  pos_q <= sat32(66'(pos_q) + sat32(prod_fl));
			L_SPIN: spin_q <= sat32(66'(spin_q) + sat32(prod_fl));
			L_HALF: half_q <= sat32(prod_h);
			default: ;
		endcase
	end

	assign done = (st_q == L_IDLE);
	assign vel_out = (op_q == LOP_IMPULSE) ? sat32(66'(vel_q) + 66'(sat32(66'(qs)))) : vel_q;
	assign spin_out = spin_q;
	assign pos_out = pos_q;
	assign half_out = half_q;

endmodule

// ===== rtl/rbi_quat.sv =====
// Merge stage: quaternion update q * (1, h) with one Q2.30 multiplier,
// one product term per cycle into a wide accumulator. Uses rbi_pkg.
module rbi_quat (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rbi_pkg::fx_t  q_in [4],
	input  rbi_pkg::fx_t  h_in [3],
	output rbi_pkg::fx_t  q_out [4],
	output logic          busy
);
	import rbi_pkg::*;

	fx_t q_q [4];
	fx_t h_q [3];
	fx_t r_q [4];
	logic [4:0] step_q;
	logic       busy_q;
	logic signed [35:0] acc_q;
	logic [1:0]  comp;
	logic [1:0]  term;
	fx_t         fa, fb;
	logic        sub;
	logic signed [63:0] prod;
	logic signed [35:0] pf;

	assign comp = step_q[4:3] ^ 2'b00;
	assign term = step_q[1:0];

	// Term table: term 0 is the plain component, 1..3 are products.
	always_comb begin
		fa = q_q[0]; fb = h_q[0]; sub = 1'b0;
		case ({comp, term})
			4'b00_01: begin fa = q_q[1]; fb = h_q[0]; sub = 1'b1; end
			4'b00_10: begin fa = q_q[2]; fb = h_q[1]; sub = 1'b1; end
			4'b00_11: begin fa = q_q[3]; fb = h_q[2]; sub = 1'b1; end
			4'b01_01: begin fa = q_q[0]; fb = h_q[0]; end
			4'b01_10: begin fa = q_q[2]; fb = h_q[2]; end
			4'b01_11: begin fa = q_q[3]; fb = h_q[1]; sub = 1'b1; end
			4'b10_01: begin fa = q_q[0]; fb = h_q[1]; end
			4'b10_10: begin fa = q_q[3]; fb = h_q[0]; end
			4'b10_11: begin fa = q_q[1]; fb = h_q[2]; sub = 1'b1; end
			4'b11_01: begin fa = q_q[0]; fb = h_q[2]; end
			4'b11_10: begin fa = q_q[1]; fb = h_q[1]; end
			4'b11_11: begin fa = q_q[2]; fb = h_q[0]; sub = 1'b1; end
			default: ;
		endcase
	end
	assign prod = fa * fb;
	assign pf = 36'(prod >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == 5'b11_0_11) busy_q <= 1'b0;
			step_q <= (term == 2'd3) ? {step_q[4:3] + 2'd1, 3'b000} : step_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= q_in;
			h_q <= h_in;
			r_q <= q_in;
		end else if (busy_q) begin
			if (term == 2'd0) acc_q <= 36'(q_q[comp]);
			else if (term == 2'd3) r_q[comp] <= sat32(66'(sub ? acc_q - pf : acc_q + pf));
			else acc_q <= sub ? acc_q - pf : acc_q + pf;
		end
	end

	assign q_out = r_q;
	assign busy = busy_q;

endmodule

// ===== rtl/rigid_body_integrator_core.sv =====
// Top level of the rigid body integrator: state registers, configuration,
// command sequencer, three axis lanes and the quaternion merge. Uses rbi_pkg.
//
//   channel  | handshake           | payload
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//   in       | in_valid/in_stall   | command, vec_x..z, quat_w, delta_time
//   out      | out_valid/out_stall | pos_x..z, rot_w..z
//
// Set and force/torque commands finish in the idle state. The time an impulse
// takes is set by the 48-step bit-serial divide by mass in each lane. A frozen
// tick runs the divide and three multiply steps per lane; with rotation free
// the lanes take three more steps and the quaternion merge follows. Reset
// returns the pose to the origin with the identity rotation. The result
// register holds while out_stall is high; the next item is taken once it has
// been handed on.
module rigid_body_integrator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          command,
	input  rbi_pkg::fx_t        vec_x,
	input  rbi_pkg::fx_t        vec_y,
	input  rbi_pkg::fx_t        vec_z,
	input  rbi_pkg::fx_t        quat_w,
	input  logic [16:0]         delta_time,
	output logic                out_valid,
	input  logic                out_stall,
	output rbi_pkg::fx_t        pos_x,
	output rbi_pkg::fx_t        pos_y,
	output rbi_pkg::fx_t        pos_z,
	output rbi_pkg::fx_t        rot_w,
	output rbi_pkg::fx_t        rot_x,
	output rbi_pkg::fx_t        rot_y,
	output rbi_pkg::fx_t        rot_z
);
	import rbi_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001, S_LANE  = 5'b00010, S_WAITL = 5'b00100,
		S_QUAT  = 5'b01000, S_EMIT  = 5'b10000
	} st_t;

	st_t        st_q;
	logic       tick_q;
	logic       qstart_q;
	logic [30:0] mass_q;
	logic [16:0] ldrag_q, adrag_q;
	logic [2:0]  mode_q;
	fx_t grav_q [3];
	fx_t pos_q [3];
	fx_t vel_q [3];
	fx_t spin_q [3];
	fx_t frc_q [3];
	fx_t trq_q [3];
	fx_t rot_q [4];
	logic [16:0] dt_q;
	fx_t out_q [7];
	logic        ovalid_q;
	// Impulse operands are latched apart from the force sums.
	fx_t imp_q [3];

	fx_t vin [3];
	fx_t lv [3];
	fx_t ls [3];
	fx_t lp [3];
	fx_t lh [3];
	fx_t qo [4];
	logic [2:0] ldone;
	logic       qbusy;
	lane_ctl_t  ctl;
	logic [30:0] meff;
	logic [16:0] lkeep, akeep;
	logic        acc_in;
	logic        kin, frz;

	assign kin = mode_q[1];
	assign frz = mode_q[2];
	assign meff = (mass_q < MASS_MIN) ? MASS_MIN : mass_q;
	assign lkeep = 17'(ONE_FX) - ((ldrag_q > 17'(ONE_FX)) ? 17'(ONE_FX) : ldrag_q);
	assign akeep = 17'(ONE_FX) - ((adrag_q > 17'(ONE_FX)) ? 17'(ONE_FX) : adrag_q);
	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;

	assign in_stall = (st_q != S_IDLE) || ovalid_q;
	assign acc_in = in_valid && !in_stall;
	assign cfg_ready = (st_q == S_IDLE);

	always_comb begin
		ctl.start = (st_q == S_LANE);
		ctl.use_grav = mode_q[0];
		ctl.frozen = frz;
		ctl.op = tick_q ? LOP_TICK : LOP_IMPULSE;
	end

	genvar g;
	generate
		for (g = 0; g < NLANES; g++) begin : g_lane
			rbi_lane u_lane (
				.clk, .arst_n, .ctl,
				.num(tick_q ? frc_q[g] : imp_q[g]),
				.mass_eff(meff), .dt(dt_q), .grav(grav_q[g]),
				.lin_keep(lkeep), .ang_keep(akeep), .torque(trq_q[g]),
				.vel_in(vel_q[g]), .spin_in(spin_q[g]), .pos_in(pos_q[g]),
				.vel_out(lv[g]), .spin_out(ls[g]), .pos_out(lp[g]),
				.half_out(lh[g]), .done(ldone[g])
			);
		end
	endgenerate

	rbi_quat u_quat (
		.clk, .arst_n, .start(qstart_q), .q_in(rot_q), .h_in(lh),
		.q_out(qo), .busy(qbusy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovalid_q <= 1'b0;
			qstart_q <= 1'b0;
			tick_q <= 1'b0;
			mass_q <= ONE_FX;
			ldrag_q <= LIN_DRAG_RST;
			adrag_q <= ANG_DRAG_RST;
			mode_q <= 3'd1;
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= '0; pos_q[i] <= '0; vel_q[i] <= '0;
				spin_q[i] <= '0; frc_q[i] <= '0; trq_q[i] <= '0;
			end
			rot_q[0] <= ONE_Q30;
			for (int i = 1; i < 4; i++) rot_q[i] <= '0;
		end else begin
			qstart_q <= 1'b0;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MASS:   mass_q <= cfg_data[30:0];
					REG_LDRAG:  ldrag_q <= cfg_data[16:0];
					REG_ADRAG:  adrag_q <= cfg_data[16:0];
					REG_MODE: begin
						mode_q <= cfg_data[2:0];
						if (cfg_data[1]) for (int i = 0; i < 3; i++) vel_q[i] <= '0;
						if (cfg_data[1] || cfg_data[2])
							for (int i = 0; i < 3; i++) spin_q[i] <= '0;
					end
					REG_GRAV_X: grav_q[0] <= cfg_data;
					REG_GRAV_Y: grav_q[1] <= cfg_data;
					REG_GRAV_Z: grav_q[2] <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (acc_in) begin
					case (command)
						CMD_TICK: begin
							if (kin) st_q <= S_EMIT;
							else begin st_q <= S_LANE; tick_q <= 1'b1; end
						end
						CMD_FORCE: for (int i = 0; i < 3; i++)
							frc_q[i] <= sat32(66'(frc_q[i]) + 66'(vin[i]));
						CMD_TORQUE: if (!frz) for (int i = 0; i < 3; i++)
							trq_q[i] <= sat32(66'(trq_q[i]) + 66'(vin[i]));
						CMD_IMPULSE: if (!kin) begin
							st_q <= S_LANE; tick_q <= 1'b0;
						end
						CMD_AIMP: if (!kin && !frz) for (int i = 0; i < 3; i++)
							spin_q[i] <= sat32(66'(spin_q[i]) + 66'(vin[i]));
						CMD_SETVEL: for (int i = 0; i < 3; i++) vel_q[i] <= vin[i];
						CMD_SETAVEL: if (!frz) for (int i = 0; i < 3; i++) spin_q[i] <= vin[i];
						CMD_SETPOS: for (int i = 0; i < 3; i++) pos_q[i] <= vin[i];
						CMD_SETROT: begin
							rot_q[0] <= quat_w;
							for (int i = 0; i < 3; i++) rot_q[i+1] <= vin[i];
						end
						default: ;
					endcase
				end
				S_LANE: st_q <= S_WAITL;
				S_WAITL: if (&ldone) begin
					for (int i = 0; i < 3; i++) vel_q[i] <= lv[i];
					if (tick_q) begin
						for (int i = 0; i < 3; i++) begin
							pos_q[i] <= lp[i];
							frc_q[i] <= '0;
							trq_q[i] <= '0;
							if (!frz) spin_q[i] <= ls[i];
						end
						if (frz) st_q <= S_EMIT;
						else begin st_q <= S_QUAT; qstart_q <= 1'b1; end
					end else st_q <= S_IDLE;
				end
				S_QUAT: if (!qbusy && !qstart_q) begin
					rot_q <= qo;
					st_q <= S_EMIT;
				end
				S_EMIT: begin
					ovalid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			dt_q <= delta_time;
			for (int i = 0; i < 3; i++) imp_q[i] <= vin[i];
		end
		if (st_q == S_EMIT) begin
			for (int i = 0; i < 3; i++) out_q[i] <= pos_q[i];
			for (int i = 0; i < 4; i++) out_q[3+i] <= rot_q[i];
		end
	end

	assign out_valid = ovalid_q;
	assign pos_x = out_q[0];
	assign pos_y = out_q[1];
	assign pos_z = out_q[2];
	assign rot_w = out_q[3];
	assign rot_x = out_q[4];
	assign rot_y = out_q[5];
	assign rot_z = out_q[6];

endmodule
